FILE: src/odt_pkg.sv
// ============================================================================
// odt_pkg - shared types and constants of the overlap depth tracker
// Item format passed from the front classifier to the back sequencer.
// ============================================================================
`default_nettype none

package odt_pkg;

   localparam int TIME_W     = 64;
   localparam int COUNT_W    = 8;
   localparam int RSP_DATA_W = 24;
   localparam int FIFO_SLOTS = 2;

   // One classified event start, as queued between front and back.
   typedef struct packed {
      logic [TIME_W-1:0] start_stamp;
      logic              final_event;
      logic              order_error;
   } odt_item_type;

endpackage

`default_nettype wire

FILE: src/odt_ram.sv
// ============================================================================
// odt_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module odt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: src/odt_front.sv
// ============================================================================
// odt_front - input acceptance and ordering check
// Flags starts that precede the last accepted in-order start and keeps the
// last in-order timestamp.
// ============================================================================
`default_nettype none

module odt_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [odt_pkg::TIME_W-1:0]   req_tdata,
   input  wire                          req_tlast,
   input  wire                          queue_full,
   output logic                         push_valid,
   output odt_pkg::odt_item_type        push_item
);

   logic [odt_pkg::TIME_W-1:0] prev_time_ff;
   logic [odt_pkg::TIME_W-1:0] prev_time_in;
   logic                       late;

   assign req_tready = !queue_full;
   assign push_valid = req_tvalid && req_tready;
   assign late       = req_tdata < prev_time_ff;

   always_comb begin
      push_item.start_stamp = req_tdata;
      push_item.final_event = req_tlast;
      push_item.order_error = late;
      prev_time_in = prev_time_ff;
      if (push_valid && !late) begin
         prev_time_in = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
      end else begin
         prev_time_ff <= prev_time_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/odt_queue.sv
// ============================================================================
// odt_queue - short item queue between front and back
// Register-based FIFO that lets the front keep accepting while the back works.
// ============================================================================
`default_nettype none

module odt_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push_valid,
   input  odt_pkg::odt_item_type  push_item,
   output logic                   full,
   output logic                   pop_avail,
   input  wire                    pop,
   output odt_pkg::odt_item_type  pop_item
);

   localparam int DEPTH = odt_pkg::FIFO_SLOTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   odt_pkg::odt_item_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff;
   logic [AW-1:0] wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff;
   logic [AW-1:0] rd_ptr_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          do_pop;

   assign full      = count_ff == CW'(DEPTH);
   assign pop_avail = count_ff != '0;
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_avail;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/odt_back.sv
// ============================================================================
// odt_back - expiry sequencer and result stage
// Pops expired starts from the start store one per cycle, appends the new
// start if in order and room remains, and drives the registered result beat.
// ============================================================================
`default_nettype none

module odt_back #(
   parameter int STORE_DEPTH = 256
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  [odt_pkg::TIME_W-1:0]       duration,
   input  wire                              item_avail,
   output logic                             item_pop,
   input  odt_pkg::odt_item_type            item,
   output logic                             store_wr_en,
   output logic [$clog2(STORE_DEPTH)-1:0]   store_wr_addr,
   output logic [odt_pkg::TIME_W-1:0]       store_wr_data,
   output logic [$clog2(STORE_DEPTH)-1:0]   store_rd_addr,
   input  wire  [odt_pkg::TIME_W-1:0]       store_rd_data,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [odt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int HW = $clog2(STORE_DEPTH + 1);
   localparam int CW = odt_pkg::COUNT_W;
   localparam int TW = odt_pkg::TIME_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXPIRE,
      ST_FINISH
   } state_type;

   state_type             state_ff;
   odt_pkg::odt_item_type item_ff;
   logic [AW-1:0]         oldest_ff;
   logic [AW-1:0]         newest_ff;
   logic [HW-1:0]         held_ff;
   logic [CW-1:0]         peak_ff;
   logic                  rsp_valid_ff;
   logic [CW-1:0]         open_ff;
   logic [CW-1:0]         peak_out_ff;
   logic                  overflow_ff;
   logic                  order_err_ff;
   logic                  done_ff;

   logic [AW-1:0]         oldest_next;
   logic [AW-1:0]         newest_next;
   logic [TW:0]           expiry_time;
   logic                  expired;
   logic                  slot_free;
   logic                  finish_fire;
   logic                  store_full;
   logic                  saturate;
   logic [CW-1:0]         open_val;
   logic [CW-1:0]         peak_val;

   assign oldest_next = (oldest_ff == AW'(STORE_DEPTH - 1)) ? '0 : oldest_ff + 1'b1;
   assign newest_next = (newest_ff == AW'(STORE_DEPTH - 1)) ? '0 : newest_ff + 1'b1;

   // A held start is expired once start plus duration reaches the new start.
   assign expiry_time = {1'b0, store_rd_data} + {1'b0, duration};
   assign expired     = expiry_time <= {1'b0, item_ff.start_stamp};

   assign slot_free   = !rsp_valid_ff || rsp_tready;
   assign finish_fire = (state_ff == ST_FINISH) && slot_free;
   assign store_full  = held_ff >= HW'(STORE_DEPTH);
   assign saturate    = (HW + CW)'(held_ff) > (HW + CW)'((1 << CW) - 1);
   assign open_val    = saturate ? {CW{1'b1}} : CW'(held_ff);
   assign peak_val    = (open_val > peak_ff) ? open_val : peak_ff;

   assign item_pop = (state_ff == ST_IDLE) && item_avail;

   always_comb begin
      store_rd_addr = oldest_ff;
      if (state_ff == ST_EXPIRE && expired) begin
         store_rd_addr = oldest_next;
      end
   end

   assign store_wr_en   = (state_ff == ST_FINISH) && slot_free &&
                          !item_ff.order_error && !store_full;
   assign store_wr_addr = newest_ff;
   assign store_wr_data = item_ff.start_stamp;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = done_ff;
   assign rsp_tdata  = {{(odt_pkg::RSP_DATA_W - 2 * CW - 2){1'b0}},
                        order_err_ff, overflow_ff, peak_out_ff, open_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         newest_ff    <= '0;
         held_ff      <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (finish_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (item_avail) begin
                  item_ff <= item;
                  if (item.order_error || held_ff == '0) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     state_ff <= ST_EXPIRE;
                  end
               end
            end
            ST_EXPIRE: begin
               if (expired) begin
                  oldest_ff <= oldest_next;
                  held_ff   <= held_ff - 1'b1;
                  if (held_ff == HW'(1)) begin
                     state_ff <= ST_FINISH;
                  end
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (slot_free) begin
                  done_ff      <= item_ff.final_event;
                  if (item_ff.order_error) begin
                     open_ff      <= '0;
                     peak_out_ff  <= peak_ff;
                     overflow_ff  <= 1'b0;
                     order_err_ff <= 1'b1;
                  end else begin
                     open_ff      <= open_val;
                     peak_out_ff  <= peak_val;
                     peak_ff      <= peak_val;
                     overflow_ff  <= store_full;
                     order_err_ff <= 1'b0;
                     if (!store_full) begin
                        newest_ff <= newest_next;
                        held_ff   <= held_ff + 1'b1;
                     end
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: src/overlap_depth_tracker_core.sv
// ============================================================================
// overlap_depth_tracker_core - sliding-window concurrency of fixed-length events
// Counts how many earlier events are still open at each new start and keeps
// the running peak of that count.
// ============================================================================
// A start beat waits in the queue until the back is idle; the back registers
//   it, retires expired held starts with one store read per cycle, then writes
//   the result register once the result slot is free, and only then takes the
//   next start. Reset (synchronous, active high) clears pointers, counts, peak,
//   previous time and the queue and sets the duration to 1; store contents are
//   not cleared, since the held count guards reads.
`default_nettype none

module overlap_depth_tracker_core #(
   parameter int STORE_DEPTH = 256
) (
   input  wire         clock,
   input  wire         reset,
   // Duration register write channel.
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [63:0] csr_data,
   // Start beats. req_tdata: start_stamp [63:0]. req_tlast: final_event.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,
   input  wire         req_tlast,
   // Result beats. rsp_tdata: open_count [7:0], peak_count [15:8],
   // store_overflow [16], order_error [17], zero [23:18].
   // rsp_tlast: trace_done.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int AW = $clog2(STORE_DEPTH);

   // Event lifetime, shared by all events. Writes are always taken.
   logic [odt_pkg::TIME_W-1:0] duration_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= odt_pkg::TIME_W'(1);
      end else if (csr_valid) begin
         duration_ff <= csr_data;
      end
   end

   // The front checks ordering and hands classified starts to the queue.
   logic                  push_valid;
   odt_pkg::odt_item_type push_item;
   logic                  queue_full;
   logic                  item_avail;
   logic                  item_pop;
   odt_pkg::odt_item_type item;

   odt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   odt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_avail  (item_avail),
      .pop        (item_pop),
      .pop_item   (item)
   );

   // Start store: a circular buffer of held starts, oldest at the read side.
   logic                       store_wr_en;
   logic [AW-1:0]              store_wr_addr;
   logic [odt_pkg::TIME_W-1:0] store_wr_data;
   logic [AW-1:0]              store_rd_addr;
   logic [odt_pkg::TIME_W-1:0] store_rd_data;

   odt_ram #(
      .WIDTH (odt_pkg::TIME_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   // The back expires old starts, appends the new one and builds the result.
   odt_back #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .duration      (duration_ff),
      .item_avail    (item_avail),
      .item_pop      (item_pop),
      .item          (item),
      .store_wr_en   (store_wr_en),
      .store_wr_addr (store_wr_addr),
      .store_wr_data (store_wr_data),
      .store_rd_addr (store_rd_addr),
      .store_rd_data (store_rd_data),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: sim/overlap_depth_tracker_core_tb.sv
// ============================================================================
// overlap_depth_tracker_core_tb - self-checking bench for the depth tracker
// Drives sorted event starts with occasional out-of-order noise under several
// event durations, predicts every result beat with a behavioral copy of the
// tracker and compares each returned beat field by field, with random idle
// cycles on the start and result channels.
// ============================================================================
`default_nettype none

module overlap_depth_tracker_core_tb;

   localparam int RING_DEPTH   = 256;
   localparam int PHASES       = 6;
   localparam int CFG_SETTLE   = 8;
   localparam int END_SETTLE   = 40;
   localparam int STALL_LIMIT  = 3000;
   localparam int REPORT_LIMIT = 40;
   localparam logic [odt_pkg::TIME_W-1:0] TIME_MAX = '1;

   // One result beat as {rsp_tlast, rsp_tdata}, highest field first.
   typedef struct packed {
      logic                        trace_done;
      logic [5:0]                  pad;
      logic                        order_error;
      logic                        store_overflow;
      logic [odt_pkg::COUNT_W-1:0] peak_count;
      logic [odt_pkg::COUNT_W-1:0] open_count;
   } depth_result_type;

   typedef enum logic [1:0] {
      ROW_BEAT,
      ROW_DURATION
   } row_kind_type;

   typedef struct {
      row_kind_type               kind;
      logic [odt_pkg::TIME_W-1:0] value;
      logic                       last;
      logic                       pinned;
      depth_result_type           want;
   } plan_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [odt_pkg::TIME_W-1:0]     csr_data = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [odt_pkg::TIME_W-1:0]     req_tdata = '0;
   logic                           req_tlast = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [odt_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;

   // A typed-in expectation travels alongside the beat it belongs to.
   logic                           beat_pinned = 1'b0;
   depth_result_type               beat_pin_want = '0;

   // Behavioral copy of the tracker.
   logic [odt_pkg::TIME_W-1:0]     start_ring [RING_DEPTH];
   int                             ring_head = 0;
   int                             ring_tail = 0;
   int                             live_count = 0;
   int                             peak_depth = 0;
   logic [odt_pkg::TIME_W-1:0]     last_start = '0;
   logic [odt_pkg::TIME_W-1:0]     window_len = 64'd1;

   depth_result_type               depth_expect_q [$];

   int failures = 0;
   int beats_taken = 0;
   int results_seen = 0;
   int overflows_seen = 0;
   int order_errors_seen = 0;
   int stall_cycles = 0;
   int tx_calm = 0;
   int rx_calm = 0;
   int rx_stall = 0;

   overlap_depth_tracker_core #(
      .STORE_DEPTH(RING_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Mostly short pauses, now and then a long one.
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(12, 48);
   endfunction

   function automatic depth_result_type pinned_result(input int open_v, input int peak_v,
                                                      input bit ovf, input bit ord,
                                                      input bit done);
      depth_result_type r;
      r = '0;
      r.open_count     = open_v[7:0];
      r.peak_count     = peak_v[7:0];
      r.store_overflow = ovf;
      r.order_error    = ord;
      r.trace_done     = done;
      return r;
   endfunction

   // For an in-order start, expires held starts whose lifetime has run out,
   // reports the remaining depth and running peak, then keeps it if there is room.
   function automatic depth_result_type predict_depth(
         input logic [odt_pkg::TIME_W-1:0] t, input logic done);
      depth_result_type r;
      r = '0;
      r.trace_done = done;
      if (t < last_start) begin
         // Out of order: nothing moves, only the peak is shown.
         r.order_error = 1'b1;
         r.peak_count  = peak_depth[7:0];
         return r;
      end
      // Held starts never exceed t, so the difference cannot wrap.
      while (live_count > 0 && (t - start_ring[ring_head]) >= window_len) begin
         ring_head  = (ring_head + 1) % RING_DEPTH;
         live_count = live_count - 1;
      end
      r.open_count = (live_count > 255) ? 8'd255 : live_count[7:0];
      if (int'(r.open_count) > peak_depth) peak_depth = r.open_count;
      r.peak_count = peak_depth[7:0];
      if (live_count >= RING_DEPTH) begin
         r.store_overflow = 1'b1;
      end else begin
         start_ring[ring_tail] = t;
         ring_tail  = (ring_tail + 1) % RING_DEPTH;
         live_count = live_count + 1;
      end
      last_start = t;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [7:0] want_v,
                                input logic [7:0] got_v);
      if (got_v !== want_v) begin
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      end
   endtask

   // Scoreboard: predicts on every accepted start beat and checks every
   // accepted result beat against the oldest expectation.
   always @(posedge clock) begin : scoreboard
      depth_result_type want;
      depth_result_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) window_len = csr_data;
         if (req_tvalid && req_tready) begin
            want = predict_depth(req_tdata, req_tlast);
            if (beat_pinned) want = beat_pin_want;
            depth_expect_q.push_back(want);
            beats_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = depth_result_type'({rsp_tlast, rsp_tdata});
            results_seen++;
            if (got.store_overflow === 1'b1) overflows_seen++;
            if (got.order_error === 1'b1) order_errors_seen++;
            if (depth_expect_q.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t: result beat with nothing expected, expected none, actual %h",
                           $time, got);
            end else begin
               want = depth_expect_q.pop_front();
               compare_field("open_count", want.open_count, got.open_count);
               compare_field("peak_count", want.peak_count, got.peak_count);
               compare_field("store_overflow", 8'(want.store_overflow), 8'(got.store_overflow));
               compare_field("order_error", 8'(want.order_error), 8'(got.order_error));
               compare_field("trace_done", 8'(want.trace_done), 8'(got.trace_done));
               compare_field("tdata padding", 8'(want.pad), 8'(got.pad));
            end
         end
      end
   end

   // Result side back-pressure: random stalls with quiet stretches between.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_stall > 0) begin
         rsp_tready <= 1'b0;
         rx_stall--;
      end else begin
         rsp_tready <= 1'b1;
         if (rx_calm > 0) begin
            rx_calm--;
         end else if ($urandom_range(0, 29) == 0) begin
            rx_calm = $urandom_range(20, 80);
         end else if ($urandom_range(0, 3) == 0) begin
            rx_stall = idle_length();
         end
      end
   end

   // Watchdog on cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Presents one start beat after an optional random gap and returns at the
   // edge where it is taken.
   task automatic send_beat(input logic [odt_pkg::TIME_W-1:0] t, input logic done,
                            input logic pin, input depth_result_type pin_want);
      int gap;
      gap = 0;
      if (tx_calm > 0) begin
         tx_calm--;
      end else if ($urandom_range(0, 29) == 0) begin
         tx_calm = $urandom_range(20, 60);
      end else if ($urandom_range(0, 2) == 0) begin
         gap = idle_length();
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid    <= 1'b1;
      req_tdata     <= t;
      req_tlast     <= done;
      beat_pinned   <= pin;
      beat_pin_want <= pin_want;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops sending and waits until every expected result has come back.
   task automatic settle_idle(input int extra);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (depth_expect_q.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_duration(input logic [odt_pkg::TIME_W-1:0] d);
      csr_valid <= 1'b1;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      plan_row_type               plan [13];
      logic [odt_pkg::TIME_W-1:0] dur;
      logic [odt_pkg::TIME_W-1:0] step_max;
      logic [odt_pkg::TIME_W-1:0] cur_t;
      logic [odt_pkg::TIME_W-1:0] t;
      logic [odt_pkg::TIME_W-1:0] delta;
      logic [63:0]                r;
      int                         n;

      // Directed rows. The first four run at the reset duration of one unit:
      // two starts at zero overlap, a start one unit later retires both, and
      // a start earlier than the previous one is refused.
      plan = '{
         '{ROW_BEAT,     64'd0,    1'b0, 1'b1, pinned_result(0, 0, 0, 0, 0)},
         '{ROW_BEAT,     64'd0,    1'b0, 1'b1, pinned_result(1, 1, 0, 0, 0)},
         '{ROW_BEAT,     64'd1,    1'b0, 1'b1, pinned_result(0, 1, 0, 0, 0)},
         '{ROW_BEAT,     64'd0,    1'b1, 1'b1, pinned_result(0, 1, 0, 1, 1)},
         '{ROW_DURATION, 64'd10,   1'b0, 1'b0, depth_result_type'('0)},
         '{ROW_BEAT,     64'd5,    1'b0, 1'b0, depth_result_type'('0)},
         '{ROW_BEAT,     64'd5,    1'b0, 1'b0, depth_result_type'('0)},
         '{ROW_BEAT,     64'd11,   1'b0, 1'b0, depth_result_type'('0)},
         '{ROW_BEAT,     64'd15,   1'b1, 1'b0, depth_result_type'('0)},
         '{ROW_BEAT,     64'd14,   1'b0, 1'b0, depth_result_type'('0)},
         '{ROW_DURATION, TIME_MAX, 1'b0, 1'b0, depth_result_type'('0)},
         '{ROW_BEAT,     64'd1000, 1'b0, 1'b0, depth_result_type'('0)},
         '{ROW_BEAT,     64'd1000, 1'b1, 1'b0, depth_result_type'('0)}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_DURATION) begin
            settle_idle(CFG_SETTLE);
            write_duration(plan[i].value);
         end else begin
            send_beat(plan[i].value, plan[i].last, plan[i].pinned, plan[i].want);
         end
      end

      // Random phases. Each one starts from a higher base so the timestamps
      // climb through the whole range; the long-lived phase fills the store
      // to overflow, and the next one retires the whole store in one beat.
      cur_t = 64'd1000;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               dur = 64'd1;
               n = 60;
               step_max = 64'd2;
            end
            1: begin
               dur = 64'($urandom_range(2, 20));
               n = 100;
               step_max = dur / 3 + 64'd1;
            end
            2: begin
               dur = TIME_MAX;
               n = 300;
               step_max = 64'd3;
            end
            3: begin
               dur = 64'($urandom) + 64'd1;
               n = 100;
               step_max = dur >> 2;
            end
            4: begin
               r = rand_word();
               dur = {2'b00, r[61:0]} | 64'd1;
               n = 80;
               step_max = dur >> 5;
            end
            default: begin
               dur = TIME_MAX;
               n = 40;
               step_max = 64'd1 << 56;
            end
         endcase

         // Every duration change waits for the tracker to go idle.
         settle_idle(CFG_SETTLE);
         write_duration(dur);

         r = rand_word();
         if ({3'(ph), r[60:0]} > cur_t) cur_t = {3'(ph), r[60:0]};

         for (int k = 0; k < n; k++) begin
            if (cur_t != 0 && $urandom_range(0, 19) == 0) begin
               // Noise: a start from the past, refused by the tracker.
               t = rand_word() % cur_t;
            end else begin
               delta = ($urandom_range(0, 3) == 0) ? 64'd0 : rand_word() % (step_max + 64'd1);
               if (delta > TIME_MAX - cur_t) delta = TIME_MAX - cur_t;
               cur_t = cur_t + delta;
               t = cur_t;
            end
            send_beat(t, $urandom_range(0, 15) == 0, 1'b0, depth_result_type'('0));
         end
      end

      // The trace ends on the largest timestamp there is.
      send_beat(TIME_MAX, 1'b1, 1'b0, depth_result_type'('0));

      settle_idle(END_SETTLE);

      $display("Run covered %0d start beats and %0d result beats over %0d duration settings.",
               beats_taken, results_seen, PHASES + 2);
      $display("Results with store overflow: %0d, with order error: %0d, final peak depth %0d.",
               overflows_seen, order_errors_seen, peak_depth);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
src/odt_pkg.sv
src/odt_ram.sv
src/odt_front.sv
src/odt_queue.sv
src/odt_back.sv
src/overlap_depth_tracker_core.sv
sim/overlap_depth_tracker_core_tb.sv
